/* src/csd_pkg.sv */
// Shared types and constants for the census stereo disparity block.
package csd_pkg;

  localparam int PIX_W   = 8;
  localparam int ROW_W   = 12;
  localparam int CHUNK_W = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_DISPARITY_SCALE = 2'd2;

  localparam logic [10:0]      RESET_WIDTH  = 11'd640;
  localparam logic [ROW_W-1:0] RESET_HEIGHT = 12'd480;
  localparam logic [7:0]       RESET_SCALE  = 8'd62;
  localparam int               MIN_WIDTH    = 16;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } step_ctl_t;

endpackage

/* src/csd_colbuf.sv */
// Column line store: read-modify-write of the stacked history rows per column.
module csd_colbuf #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIDE = 13,
  parameter int ADDR_W      = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  logic                                       rd_en,
  input  logic [ADDR_W-1:0]                          rd_addr,
  input  logic [csd_pkg::PIX_W-1:0]                  left_pixel,
  input  logic [csd_pkg::PIX_W-1:0]                  right_pixel,
  output logic                                       col_valid,
  output logic [WINDOW_SIDE-1:0][csd_pkg::PIX_W-1:0] left_col,
  output logic [WINDOW_SIDE-1:0][csd_pkg::PIX_W-1:0] right_col
);
  import csd_pkg::*;

  localparam int HIST   = WINDOW_SIDE - 1;
  localparam int WORD_W = 2 * HIST * PIX_W;

  logic [WORD_W-1:0]           mem [MAX_WIDTH];
  logic [WORD_W-1:0]           rdata;
  logic [HIST-1:0][PIX_W-1:0]  left_hist;
  logic [HIST-1:0][PIX_W-1:0]  right_hist;
  logic [ADDR_W-1:0]           addr_q;
  logic [PIX_W-1:0]            left_q;
  logic [PIX_W-1:0]            right_q;
  logic                        wr_en;

  assign {right_hist, left_hist} = rdata;
  assign left_col  = {left_q, left_hist};
  assign right_col = {right_q, right_hist};
  assign wr_en     = col_valid && adv;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr_q] <= {right_col[WINDOW_SIDE-1:1], left_col[WINDOW_SIDE-1:1]};
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      addr_q  <= rd_addr;
      left_q  <= left_pixel;
      right_q <= right_pixel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_valid <= 1'b0;
    end else if (adv) begin
      col_valid <= rd_en;
    end
  end

endmodule

/* src/csd_match.sv */
// Census windows, Hamming costs per disparity and first-minimum selection.
module csd_match #(
  parameter int WINDOW_SIDE = 13,
  parameter int DISPARITIES = 16,
  parameter int COL_W       = 10
) (
  input  logic                                       clk,
  input  logic                                       rst,
  input  logic                                       adv,
  input  csd_pkg::step_ctl_t                         in_ctl,
  input  logic [WINDOW_SIDE-1:0][csd_pkg::PIX_W-1:0] left_col,
  input  logic [WINDOW_SIDE-1:0][csd_pkg::PIX_W-1:0] right_col,
  input  logic [COL_W-1:0]                           ox,
  input  logic [csd_pkg::ROW_W-1:0]                  oy,
  input  logic [COL_W:0]                             w_eff,
  input  logic [csd_pkg::ROW_W-1:0]                  h_eff,
  output csd_pkg::step_ctl_t                         res_ctl,
  output logic [$clog2(DISPARITIES)-1:0]             res_disp
);
  import csd_pkg::*;

  localparam int WS   = WINDOW_SIDE;
  localparam int R    = (WS - 1) / 2;
  localparam int N    = WS * WS;
  localparam int NCH  = (N + CHUNK_W - 1) / CHUNK_W;
  localparam int NPAD = NCH * CHUNK_W;
  localparam int CSW  = $clog2(N + 1);
  localparam int CHS  = $clog2(CHUNK_W + 1);
  localparam int LV   = $clog2(DISPARITIES);
  localparam int DP   = 1 << LV;

  logic signed [COL_W+1:0] colx [WS];
  logic signed [ROW_W+1:0] rowy [WS];
  logic [WS-1:0]           colok;
  logic [WS-1:0]           rowok;

  logic [WS-1:0][PIX_W-1:0] lwin [WS];
  logic [WS-1:0][PIX_W-1:0] rwin [WS];
  logic [WS-1:0]            colok_q;
  logic [WS-1:0]            rowok_q;
  logic [COL_W-1:0]         m1_ox;
  step_ctl_t                m1_ctl;

  logic [N-1:0]             lcen;
  logic [N-1:0]             rcen;
  logic [DISPARITIES-1:0]   dvalid;
  logic [N-1:0]             lcen_q;
  logic [N-1:0]             rcline [DISPARITIES];
  logic [DISPARITIES-1:0]   dvalid_q;
  step_ctl_t                m2_ctl;

  logic [NPAD-1:0]          diff [DISPARITIES];
  logic [CHS-1:0]           psum [DISPARITIES][NCH];
  logic [DISPARITIES-1:0]   dvalid_m3;
  step_ctl_t                m3_ctl;

  logic [CSW-1:0]           cost [DP];
  logic [CSW-1:0]           node_cost [LV+1][DP];
  logic [LV-1:0]            node_idx [LV+1][DP];
  step_ctl_t                lv_ctl [LV+1];

  always_comb begin
    for (int i = 0; i < WS; i++) begin
      colx[i]  = $signed({2'b00, ox}) + $signed((COL_W+2)'(i - R));
      colok[i] = !colx[i][COL_W+1] && (colx[i] < $signed({1'b0, w_eff}));
      rowy[i]  = $signed({2'b00, oy}) + $signed((ROW_W+2)'(i - R));
      rowok[i] = !rowy[i][ROW_W+1] && (rowy[i] < $signed({2'b00, h_eff}));
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      colok_q <= colok;
      rowok_q <= rowok;
      m1_ox   <= ox;
      if (in_ctl.valid) begin
        for (int c = 0; c < WS - 1; c++) begin
          lwin[c] <= lwin[c+1];
          rwin[c] <= rwin[c+1];
        end
        lwin[WS-1] <= left_col;
        rwin[WS-1] <= right_col;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < WS; r++) begin
      for (int c = 0; c < WS; c++) begin
        lcen[r*WS+c] = colok_q[c] && rowok_q[r] && (lwin[c][r] > lwin[R][R]);
        rcen[r*WS+c] = colok_q[c] && rowok_q[r] && (rwin[c][r] > rwin[R][R]);
      end
    end
    for (int d = 0; d < DISPARITIES; d++) begin
      dvalid[d] = (7'(d) <= 7'(m1_ox)) || (COL_W > 7 && (m1_ox >> 7) != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lcen_q   <= lcen;
      dvalid_q <= dvalid;
      if (m1_ctl.valid) begin
        rcline[0] <= rcen;
        for (int d = 1; d < DISPARITIES; d++) begin
          rcline[d] <= rcline[d-1];
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < DISPARITIES; d++) begin
      diff[d] = NPAD'(lcen_q ^ rcline[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dvalid_m3 <= dvalid_q;
      for (int d = 0; d < DISPARITIES; d++) begin
        for (int ch = 0; ch < NCH; ch++) begin
          psum[d][ch] <= CHS'($countones(diff[d][ch*CHUNK_W +: CHUNK_W]));
        end
      end
    end
  end

  always_comb begin
    for (int d = 0; d < DP; d++) begin
      cost[d] = '1;
    end
    for (int d = 0; d < DISPARITIES; d++) begin
      cost[d] = '0;
      for (int ch = 0; ch < NCH; ch++) begin
        cost[d] = cost[d] + CSW'(psum[d][ch]);
      end
      if (!dvalid_m3[d]) begin
        cost[d] = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int d = 0; d < DP; d++) begin
        node_cost[0][d] <= cost[d];
        node_idx[0][d]  <= LV'(d);
      end
      for (int l = 0; l < LV; l++) begin
        for (int j = 0; j < DP / 2; j++) begin
          if (node_cost[l][2*j+1] < node_cost[l][2*j]) begin
            node_cost[l+1][j] <= node_cost[l][2*j+1];
            node_idx[l+1][j]  <= node_idx[l][2*j+1];
          end else begin
            node_cost[l+1][j] <= node_cost[l][2*j];
            node_idx[l+1][j]  <= node_idx[l][2*j];
          end
        end
        for (int j = DP / 2; j < DP; j++) begin
          node_cost[l+1][j] <= '1;
          node_idx[l+1][j]  <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_ctl <= '0;
      m2_ctl <= '0;
      m3_ctl <= '0;
      for (int l = 0; l <= LV; l++) begin
        lv_ctl[l] <= '0;
      end
    end else if (adv) begin
      m1_ctl    <= in_ctl;
      m2_ctl    <= m1_ctl;
      m3_ctl    <= m2_ctl;
      lv_ctl[0] <= m3_ctl;
      for (int l = 0; l < LV; l++) begin
        lv_ctl[l+1] <= lv_ctl[l];
      end
    end
  end

  assign res_ctl  = lv_ctl[LV];
  assign res_disp = node_idx[LV][0];

endmodule

/* src/census_stereo_disparity_top.sv */
// Census stereo matcher top level: raster counters, pipeline control, output skid.
//
// Feed left/right grey pixel pairs in raster order on the input channel
// (kind = pixel); after the last pixel of a frame send drain ticks (kind =
// drain) until the frame's last result appears. A drain tick inside the
// image is taken and dropped; a pixel pair past the image end counts as a
// drain tick. The result for pixel (x,y) follows the transfer of raster
// index (y+R)*W + x+R, R = (WINDOW_SIDE-1)/2.
// One item is taken per cycle while the input is not stalled; the rate
// is set by the column line store, read and written back once per item.
// A result waits in the output register; one more lands in a skid stage,
// and then the input stalls and the pipeline holds until the receiver
// takes a transfer. Reset sets the size and scale registers to 640 x 480
// and 62 and starts a frame at the origin; the line store is not cleared
// and needs no clearing pass. A write of the width or height register
// restarts the frame; write registers only while the block is idle.
module census_stereo_disparity_top #(
  parameter int MAX_WIDTH   = 1024,
  parameter int WINDOW_SIDE = 13,
  parameter int DISPARITIES = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [7:0]                         left_pixel,
  input  logic [7:0]                         right_pixel,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         disparity_code,
  output logic [3:0]                         best_disparity,
  output logic                               last_of_frame,
  input  logic                               cfg_write,
  input  logic [csd_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [csd_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import csd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int R  = (WINDOW_SIDE - 1) / 2;
  localparam int DW = $clog2(DISPARITIES);

  logic [10:0]      image_width;
  logic [ROW_W-1:0] image_height;
  logic [7:0]       disparity_scale;
  logic [CW:0]      w_eff;
  logic [ROW_W-1:0] h_eff;

  logic [ROW_W:0]   row;
  logic [CW-1:0]    col;
  logic [CW-1:0]    ox;
  logic [ROW_W-1:0] oy;

  logic             adv;
  logic             accept;
  logic             in_image;
  logic             count;
  logic             emit;
  logic             last;
  logic             col_wrap;
  logic             ox_wrap;

  step_ctl_t        s1_ctl;
  logic [CW-1:0]    s1_ox;
  logic [ROW_W-1:0] s1_oy;

  logic                                col_valid;
  logic [WINDOW_SIDE-1:0][PIX_W-1:0]   left_col;
  logic [WINDOW_SIDE-1:0][PIX_W-1:0]   right_col;
  step_ctl_t                           res_ctl;
  logic [DW-1:0]                       res_disp;
  logic                                res_valid;
  logic [7:0]                          res_code;

  logic             sk_valid;
  logic [7:0]       sk_code;
  logic [3:0]       sk_disp;
  logic             sk_last;
  logic             take;

  always_comb begin
    if (image_width < 11'(MIN_WIDTH)) begin
      w_eff = (CW+1)'(MIN_WIDTH);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(image_width);
    end
    h_eff = (image_height == '0) ? ROW_W'(1) : image_height;
  end

  assign adv      = !sk_valid;
  assign in_stall = sk_valid;
  assign accept   = in_valid && !in_stall;
  assign in_image = row < {1'b0, h_eff};
  assign count    = accept && !(in_image && kind == KIND_DRAIN);
  assign emit     = (row > (ROW_W+1)'(R)) || (row == (ROW_W+1)'(R) && col >= CW'(R));
  assign col_wrap = ({1'b0, col} + 1'b1) == w_eff;
  assign ox_wrap  = ({1'b0, ox} + 1'b1) == w_eff;
  assign last     = emit && ox_wrap && (oy == h_eff - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= RESET_WIDTH;
      image_height    <= RESET_HEIGHT;
      disparity_scale <= RESET_SCALE;
      row             <= '0;
      col             <= '0;
      ox              <= '0;
      oy              <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH: begin
          image_width <= cfg_data[10:0];
          row         <= '0;
          col         <= '0;
          ox          <= '0;
          oy          <= '0;
        end
        CFG_IMAGE_HEIGHT: begin
          image_height <= cfg_data[ROW_W-1:0];
          row          <= '0;
          col          <= '0;
          ox           <= '0;
          oy           <= '0;
        end
        CFG_DISPARITY_SCALE: begin
          disparity_scale <= cfg_data[7:0];
        end
        default: begin
        end
      endcase
    end else if (count) begin
      if (last) begin
        row <= '0;
        col <= '0;
        ox  <= '0;
        oy  <= '0;
      end else begin
        if (col_wrap) begin
          col <= '0;
          row <= row + 1'b1;
        end else begin
          col <= col + 1'b1;
        end
        if (emit) begin
          if (ox_wrap) begin
            ox <= '0;
            oy <= oy + 1'b1;
          end else begin
            ox <= ox + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (adv) begin
      s1_ctl.valid <= count;
      s1_ctl.emit  <= count && emit;
      s1_ctl.last  <= count && last;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ox <= ox;
      s1_oy <= oy;
    end
  end

  csd_colbuf #(
    .MAX_WIDTH   (MAX_WIDTH),
    .WINDOW_SIDE (WINDOW_SIDE),
    .ADDR_W      (CW)
  ) u_colbuf (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .rd_en       (count),
    .rd_addr     (col),
    .left_pixel  (left_pixel),
    .right_pixel (right_pixel),
    .col_valid   (col_valid),
    .left_col    (left_col),
    .right_col   (right_col)
  );

  csd_match #(
    .WINDOW_SIDE (WINDOW_SIDE),
    .DISPARITIES (DISPARITIES),
    .COL_W       (CW)
  ) u_match (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_ctl    ('{valid: col_valid && s1_ctl.valid, emit: s1_ctl.emit, last: s1_ctl.last}),
    .left_col  (left_col),
    .right_col (right_col),
    .ox        (s1_ox),
    .oy        (s1_oy),
    .w_eff     (w_eff),
    .h_eff     (h_eff),
    .res_ctl   (res_ctl),
    .res_disp  (res_disp)
  );

  assign res_valid = res_ctl.valid && res_ctl.emit && adv;
  assign res_code  = 8'(disparity_scale * res_disp);
  assign take      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (sk_valid) begin
      if (take) begin
        out_valid <= 1'b1;
        sk_valid  <= 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        sk_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sk_valid) begin
      if (take) begin
        disparity_code <= sk_code;
        best_disparity <= sk_disp;
        last_of_frame  <= sk_last;
      end
    end else if (res_valid) begin
      if (!out_valid || take) begin
        disparity_code <= res_code;
        best_disparity <= 4'(res_disp);
        last_of_frame  <= res_ctl.last;
      end else begin
        sk_code <= res_code;
        sk_disp <= 4'(res_disp);
        sk_last <= res_ctl.last;
      end
    end
  end

endmodule
